@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the handle pool.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/ghp_pkg.sv @@
// Package for the generational handle pool: sizes, codes, memory words.
// Used by the top level; has no dependencies.
package ghp_pkg;

    localparam int SLOTS    = 1024;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int GEN_W    = 16;
    localparam int HIDX_W   = 16;
    localparam int HANDLE_W = GEN_W + HIDX_W;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SIDX_W   = 10;
    localparam int LIVE_W   = 10;

    localparam logic [GEN_W-1:0] GEN_START = GEN_W'(1);

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Ring entries carry the generation the slot will be handed out with.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] idx;
    } ring_word_t;

    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
    } slot_word_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ rtl/generational_handle_pool_unit.sv @@
// Generational handle pool: allocate, free and check 32-bit handles.
// Uses ghp_pkg, ghp_ram and assert_macros.svh.
//
// Request channel (req_valid/req_ready): cmd and handle. Response channel
// (rsp_valid/rsp_ready): status, handle_out, slot_index and live_count, one
// response per request, in order.
// A request is read from the memories in the cycle it is accepted and executed
// in the next, where the response register is loaded and state is written back.
// The response register and rsp_valid are loaded from the EXEC state; a new
// request is not taken until the current one has been written back (the
// single read-modify-write pass over the ring and slot RAMs).
// After reset a clearing pass writes every ring and slot entry (SLOTS of
// each), with req_ready low throughout.
// When the receiver stalls, the response is held in its register and no new
// request is taken until that response has gone or leaves in the same cycle.
module generational_handle_pool_unit
    import ghp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [HANDLE_W-1:0] handle,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [SIDX_W-1:0]   slot_index,
    output logic [LIVE_W-1:0]   live_count
);

`include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    live_reg, live_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] handle_out_reg, handle_out_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;
    logic [IDX_W-1:0]    live_out_reg;

    logic       accept;
    logic       ring_we, slot_we;
    logic [IDX_W-1:0] ring_waddr, slot_waddr;
    ring_word_t ring_wdata, ring_rdata;
    slot_word_t slot_wdata, slot_rdata;

    logic [HIDX_W-1:0] req_idx;
    logic [GEN_W-1:0]  req_gen;
    logic              in_range;
    logic [IDX_W-1:0]  tail_inc;
    logic [GEN_W-1:0]  gen_bump;
    logic [IDX_W:0]    free_cnt;

    ghp_ram #(
        .WIDTH ($bits(ring_word_t)),
        .DEPTH (SLOTS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    ghp_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (handle[IDX_W-1:0]),
        .rdata (slot_rdata)
    );

    assign accept = req_valid && req_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Request side handshake
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  req_ready = !rsp_valid_reg || rsp_ready;
            default:  req_ready = 1'b0;
        endcase
    end

    assign req_idx  = handle_reg[HIDX_W-1:0];
    assign req_gen  = handle_reg[HANDLE_W-1:HIDX_W];
    assign in_range = {1'b0, req_idx} < (HIDX_W + 1)'(SLOTS);
    assign tail_inc = ring_next(tail_reg);
    assign gen_bump = slot_rdata.gen + 1'b1;

    // Clearing writes, or in execute the response and the write-back from the RAM read data
    always_comb
    begin
        status_next     = STATUS_OK;
        handle_out_next = '0;
        sidx_next       = '0;
        head_next       = head_reg;
        tail_next       = tail_reg;
        live_next       = live_reg;
        ring_we         = 1'b0;
        ring_waddr      = clr_reg;
        ring_wdata      = '{gen: GEN_START, idx: clr_reg};
        slot_we         = 1'b0;
        slot_waddr      = clr_reg;
        slot_wdata      = '{live: 1'b0, gen: GEN_START};

        if (state_reg == ST_CLEAR)
        begin
            ring_we = 1'b1;
            slot_we = 1'b1;
        end
        else if (state_reg == ST_EXEC)
        begin
            case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (head_reg == tail_reg)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        handle_out_next = {ring_rdata.gen, HIDX_W'(ring_rdata.idx)};
                        sidx_next       = ring_rdata.idx;
                        head_next       = ring_next(head_reg);
                        live_next       = live_reg + 1'b1;
                        slot_we         = 1'b1;
                        slot_waddr      = ring_rdata.idx;
                        slot_wdata      = '{live: 1'b1, gen: ring_rdata.gen};
                    end
                end
                CMD_FREE, CMD_CHECK:
                begin
                    if (!in_range)
                    begin
                        status_next = STATUS_STALE;
                    end
                    else
                    begin
                        sidx_next = req_idx[IDX_W-1:0];
                        if (slot_rdata.gen != req_gen)
                        begin
                            status_next = STATUS_STALE;
                        end
                        else if (cmd_reg == CMD_FREE)
                        begin
                            if (!slot_rdata.live)
                            begin
                                status_next = STATUS_STALE;
                            end
                            else
                            begin
                                // retire the slot and push it with its next generation
                                slot_we    = 1'b1;
                                slot_waddr = req_idx[IDX_W-1:0];
                                slot_wdata = '{live: 1'b0, gen: gen_bump};
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - 1'b1;
                                end
                                tail_next  = tail_inc;
                                ring_we    = 1'b1;
                                ring_waddr = tail_inc;
                                ring_wdata = '{gen: gen_bump, idx: req_idx[IDX_W-1:0]};
                            end
                        end
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= IDX_W'(SLOTS - 1);
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            live_reg  <= live_next;
            if (state_reg == ST_EXEC)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            handle_reg <= handle;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
            sidx_reg       <= sidx_next;
            live_out_reg   <= live_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign slot_index = SIDX_W'(sidx_reg);
    assign live_count = LIVE_W'(live_out_reg);

    // Free entries in the ring, for the occupancy check
    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            free_cnt = {1'b0, tail_reg} - {1'b0, head_reg};
        end
        else
        begin
            free_cnt = {1'b0, tail_reg} + (IDX_W + 1)'(SLOTS) - {1'b0, head_reg};
        end
    end

    `ASSERT_ALWAYS(a_ring_occupancy, clk, rst_n, ({1'b0, live_reg} + free_cnt) == (IDX_W + 1)'(SLOTS - 1))
    `ASSERT_IMPLIES(a_no_req_in_clear, clk, rst_n, state_reg == ST_CLEAR, !req_ready)
    `ASSERT_NEXT(a_rsp_follows_exec, clk, rst_n, state_reg == ST_EXEC, rsp_valid)

endmodule

@@ rtl/ghp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
